/* design/tdsl_pkg.sv */
package tdsl_pkg;

    // Fixed datapath widths of the block.
    localparam int MAG_W  = 32;
    localparam int ACC_W  = 64;
    localparam int PROD_W = 96;
    localparam int Q_W    = 34;

    // Saturation limits of the signed 64-bit accumulators.
    localparam logic [ACC_W-1:0] SAT_POS = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] SAT_NEG = {1'b1, {(ACC_W-1){1'b0}}};

    // Result status codes.
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_TOL = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // Sequencer states.
    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_MUL_LO  = 9'b000000010,
        S_MUL_HI  = 9'b000000100,
        S_MUL_SUM = 9'b000001000,
        S_CLAMP   = 9'b000010000,
        S_ACC     = 9'b000100000,
        S_CHECK   = 9'b001000000,
        S_DIV     = 9'b010000000,
        S_FINISH  = 9'b100000000
    } state_t;

    // Product terms formed for one row, in issue order.
    typedef enum logic [2:0] {
        OP_GG  = 3'd0,
        OP_BG  = 3'd1,
        OP_BGG = 3'd2,
        OP_PG  = 3'd3,
        OP_APG = 3'd4,
        OP_CPG = 3'd5
    } op_t;

    // Phase strobes of the shared multiplier.
    typedef struct packed {
        logic lo;
        logic hi;
        logic sum;
    } mul_ctrl_t;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* design/tdsl_if.sv */
// Row channel: one Hessian row and its gradient element per transaction.
interface tdsl_row_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sub_diag;
    logic signed [DATA_WIDTH-1:0] main_diag;
    logic signed [DATA_WIDTH-1:0] super_diag;
    logic signed [DATA_WIDTH-1:0] grad_elem;
    logic                         last_row;

    modport source (
        output valid, sub_diag, main_diag, super_diag, grad_elem, last_row,
        input  ready
    );
    modport sink (
        input  valid, sub_diag, main_diag, super_diag, grad_elem, last_row,
        output ready
    );
endinterface

// Result channel: step length and status per transaction.
interface tdsl_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] step_alpha;
    logic        [1:0]  status;

    modport source (
        output valid, step_alpha, status,
        input  ready
    );
    modport sink (
        input  valid, step_alpha, status,
        output ready
    );
endinterface

// Configuration channel: denominator tolerance write per transaction.
interface tdsl_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

/* design/tdsl_mul.sv */
module tdsl_mul
    import tdsl_pkg::*;
(
    input  logic              clk,
    input  mul_ctrl_t         ctrl,
    input  logic [ACC_W-1:0]  x,
    input  logic [MAG_W-1:0]  y,
    output logic [PROD_W-1:0] prod
);

    logic [MAG_W-1:0]  x_half;
    logic [ACC_W-1:0]  pp_reg;
    logic [ACC_W-1:0]  lo_reg;
    logic [PROD_W-1:0] prod_reg;

    // The low half of x goes in first, the high half second.
    assign x_half = ctrl.hi ? x[ACC_W-1:MAG_W] : x[MAG_W-1:0];

    // One 32x32 partial product per cycle, then a combining add.
    always_ff @(posedge clk)
    begin
        if (ctrl.lo || ctrl.hi)
        begin
            pp_reg <= x_half * y;
        end
        if (ctrl.hi)
        begin
            lo_reg <= pp_reg;
        end
        if (ctrl.sum)
        begin
            prod_reg <= {pp_reg, {MAG_W{1'b0}}} + {{MAG_W{1'b0}}, lo_reg};
        end
    end

    assign prod = prod_reg;

endmodule

/* design/tdsl_div.sv */
module tdsl_div
    import tdsl_pkg::*;
#(
    parameter int STEPS = 88
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ACC_W-1:0] n,
    input  logic [ACC_W-1:0] d,
    output div_stat_t        stat,
    output logic [Q_W-1:0]   q
);

    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ACC_W-1:0] r_reg;
    logic [ACC_W-1:0] n_reg;
    logic [ACC_W-1:0] d_reg;
    logic [Q_W-1:0]   q_reg;

    logic [ACC_W-1:0] r_shift;
    logic             q_bit;
    logic [Q_W-1:0]   q_next;

    // Restoring division step. The remainder stays below d, which is at most
    // 2^63, so the shifted remainder fits in 64 bits.
    always_comb
    begin
        r_shift = {r_reg[ACC_W-2:0], n_reg[ACC_W-1]};
        q_bit   = (r_shift >= d_reg);
        // Once the quotient reaches 2^32 it is pinned at 2^33.
        if (q_reg[Q_W-1] || q_reg[Q_W-2])
        begin
            q_next = {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            q_next = {q_reg[Q_W-2:0], q_bit};
        end
    end

    // Control: busy while the division steps run, then a one-cycle done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Datapath: dividend bits feed in MSB first, then zeros.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            n_reg <= n;
            d_reg <= d;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= q_bit ? (r_shift - d_reg) : r_shift;
            n_reg <= {n_reg[ACC_W-2:0], 1'b0};
            q_reg <= q_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign q         = q_reg;

endmodule

/* design/tridiag_exact_step_length.sv */
// Exact steepest-descent step length alpha = (g.g)/(g.Hg) for a tridiagonal
// Hessian, streamed one row per transaction on the row channel. A transaction
// with last_row set closes the vector and yields one transaction on the result
// channel: alpha in Q16.16 and a status (ok, denominator below tolerance, or
// saturation). The cfg channel writes the denominator tolerance; it is always
// ready and is meant to be written while the block is idle.
// All products go through one shared 32x32 multiplier, two partial products
// per term, so a row occupies the block while its terms are formed, and the
// first row of a vector has fewer terms than each later row. The last row adds
// the tolerance check and the bit-serial divider (one quotient bit a cycle);
// with a denominator below tolerance the divider is skipped.
// Row ready is high only while the sequencer is idle. A finished result sits
// in an output register; further rows are still taken while it waits, and only
// the next result stalls until the receiver takes the pending one.
// Reset empties the output register, clears the vector state and sets the
// tolerance to 1.
module tridiag_exact_step_length
    import tdsl_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    tdsl_row_if.sink   row,
    tdsl_cfg_if.sink   cfg,
    tdsl_res_if.source result
);

    localparam int DIV_STEPS = ACC_W + FRAC_BITS + 16;

    function automatic logic [MAG_W-1:0] mag_of(input logic [DATA_WIDTH-1:0] v);
        logic [DATA_WIDTH-1:0] neg;
        neg = -v;
        return MAG_W'(v[DATA_WIDTH-1] ? neg : v);
    endfunction

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    // Current row, as magnitude and sign.
    logic [MAG_W-1:0] a_mag_reg, b_mag_reg, c_mag_reg, g_mag_reg;
    logic             a_sgn_reg, b_sgn_reg, c_sgn_reg, g_sgn_reg;
    logic             last_reg;

    // Vector state.
    logic             first_reg;
    logic [MAG_W-1:0] pg_mag_reg, pc_mag_reg;
    logic             pg_sgn_reg, pc_sgn_reg;
    logic [ACC_W-1:0] sum_gg_reg, sum_ghg_reg;
    logic             sat_reg;

    // Intermediate term and finishing flags.
    logic [ACC_W-1:0] t_reg;
    logic             t_sgn_reg;
    logic [ACC_W-1:0] term_reg;
    logic             err_reg;
    logic             neg_reg;
    logic [31:0]      tol_reg;

    // Output register.
    logic               res_valid_reg;
    logic signed [31:0] alpha_reg;
    logic [1:0]         status_reg;

    logic [ACC_W-1:0]  op_x;
    logic [MAG_W-1:0]  op_y;
    logic              op_sgn;
    logic              op_to_t;
    mul_ctrl_t         mul_ctrl;
    logic [PROD_W-1:0] prod;
    logic              prod_over;
    logic [ACC_W-1:0]  prod_clamp;
    logic [ACC_W-1:0]  term_next;
    logic [ACC_W-1:0]  acc_a;
    logic [ACC_W-1:0]  acc_s;
    logic              acc_ovf;
    logic [ACC_W-1:0]  acc_res;
    logic              row_done;
    logic [ACC_W-1:0]  ghg_neg;
    logic [ACC_W-1:0]  dmag;
    logic              tol_fail;
    logic              div_start;
    div_stat_t         div_stat;
    logic [Q_W-1:0]    div_q;
    logic              q_big;
    logic [31:0]       q_mag;
    logic [31:0]       fin_alpha;
    logic [1:0]        fin_status;
    logic              out_free;
    logic              row_fire;

    assign row.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign row_fire  = row.valid && (state_reg == S_IDLE);

    // Operand selection for the term being formed.
    always_comb
    begin
        op_x    = '0;
        op_y    = '0;
        op_sgn  = 1'b0;
        op_to_t = 1'b0;
        unique case (op_reg)
            OP_GG:
            begin
                op_x = ACC_W'(g_mag_reg);
                op_y = g_mag_reg;
            end
            OP_BG:
            begin
                op_x    = ACC_W'(b_mag_reg);
                op_y    = g_mag_reg;
                op_sgn  = b_sgn_reg ^ g_sgn_reg;
                op_to_t = 1'b1;
            end
            OP_BGG:
            begin
                op_x   = t_reg;
                op_y   = g_mag_reg;
                op_sgn = t_sgn_reg ^ g_sgn_reg;
            end
            OP_PG:
            begin
                op_x    = ACC_W'(pg_mag_reg);
                op_y    = g_mag_reg;
                op_sgn  = pg_sgn_reg ^ g_sgn_reg;
                op_to_t = 1'b1;
            end
            OP_APG:
            begin
                op_x   = t_reg;
                op_y   = a_mag_reg;
                op_sgn = t_sgn_reg ^ a_sgn_reg;
            end
            OP_CPG:
            begin
                op_x   = t_reg;
                op_y   = pc_mag_reg;
                op_sgn = t_sgn_reg ^ pc_sgn_reg;
            end
            default:
            begin
                op_x = '0;
            end
        endcase
    end

    assign mul_ctrl.lo  = (state_reg == S_MUL_LO);
    assign mul_ctrl.hi  = (state_reg == S_MUL_HI);
    assign mul_ctrl.sum = (state_reg == S_MUL_SUM);

    tdsl_mul u_mul (
        .clk  (clk),
        .ctrl (mul_ctrl),
        .x    (op_x),
        .y    (op_y),
        .prod (prod)
    );

    // Clamp the exact product to the signed 64-bit range and apply its sign.
    always_comb
    begin
        prod_over  = (|prod[PROD_W-1:ACC_W]) ||
                     (prod[ACC_W-1] && (!op_sgn || (|prod[ACC_W-2:0])));
        prod_clamp = prod_over ? (op_sgn ? SAT_NEG : SAT_POS) : prod[ACC_W-1:0];
        term_next  = op_sgn ? -prod_clamp : prod_clamp;
    end

    // Saturating accumulate into g.g or g.Hg.
    always_comb
    begin
        acc_a   = (op_reg == OP_GG) ? sum_gg_reg : sum_ghg_reg;
        acc_s   = acc_a + term_reg;
        acc_ovf = (acc_a[ACC_W-1] == term_reg[ACC_W-1]) &&
                  (acc_s[ACC_W-1] != acc_a[ACC_W-1]);
        acc_res = acc_ovf ? (acc_a[ACC_W-1] ? SAT_NEG : SAT_POS) : acc_s;
    end

    // A row ends after b.g.g on the first row, else after the c term.
    assign row_done = ((op_reg == OP_BGG) && first_reg) || (op_reg == OP_CPG);

    // Denominator magnitude and tolerance test.
    always_comb
    begin
        ghg_neg  = -sum_ghg_reg;
        dmag     = sum_ghg_reg[ACC_W-1] ? ghg_neg : sum_ghg_reg;
        tol_fail = (dmag == '0) || (dmag < ACC_W'(tol_reg));
    end

    assign div_start = (state_reg == S_CHECK) && !tol_fail;

    // g.g is a sum of squares and never goes negative, so it feeds the
    // divider as it is.
    tdsl_div #(
        .STEPS (DIV_STEPS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (sum_gg_reg),
        .d     (dmag),
        .stat  (div_stat),
        .q     (div_q)
    );

    // Final alpha with sign and Q16.16 saturation.
    always_comb
    begin
        q_big      = 1'b0;
        q_mag      = '0;
        fin_alpha  = '0;
        fin_status = ST_TOL;
        if (!err_reg)
        begin
            if (neg_reg)
            begin
                q_big     = (div_q > Q_W'(33'h080000000));
                q_mag     = q_big ? 32'h80000000 : div_q[31:0];
                fin_alpha = -q_mag;
            end
            else
            begin
                q_big     = (div_q > Q_W'(33'h07FFFFFFF));
                q_mag     = q_big ? 32'h7FFFFFFF : div_q[31:0];
                fin_alpha = q_mag;
            end
            fin_status = (q_big || sat_reg) ? ST_SAT : ST_OK;
        end
    end

    assign out_free = !res_valid_reg || result.ready;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (row.valid)
                begin
                    state_next = S_MUL_LO;
                    op_next    = OP_GG;
                end
            end
            S_MUL_LO:
            begin
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                state_next = S_MUL_SUM;
            end
            S_MUL_SUM:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (op_to_t)
                begin
                    state_next = S_MUL_LO;
                    op_next    = op_t'(op_reg + 3'd1);
                end
                else
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (row_done)
                begin
                    state_next = last_reg ? S_CHECK : S_IDLE;
                end
                else
                begin
                    state_next = S_MUL_LO;
                    op_next    = op_t'(op_reg + 3'd1);
                end
            end
            S_CHECK:
            begin
                state_next = tol_fail ? S_FINISH : S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and vector state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_GG;
            first_reg     <= 1'b1;
            pg_mag_reg    <= '0;
            pg_sgn_reg    <= 1'b0;
            pc_mag_reg    <= '0;
            pc_sgn_reg    <= 1'b0;
            sum_gg_reg    <= '0;
            sum_ghg_reg   <= '0;
            sat_reg       <= 1'b0;
            tol_reg       <= 32'd1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;

            if (cfg.valid)
            begin
                tol_reg <= cfg.data;
            end

            if ((state_reg == S_CLAMP) && !op_to_t && prod_over)
            begin
                sat_reg <= 1'b1;
            end

            if (state_reg == S_ACC)
            begin
                if (op_reg == OP_GG)
                begin
                    sum_gg_reg <= acc_res;
                end
                else
                begin
                    sum_ghg_reg <= acc_res;
                end
                if (acc_ovf)
                begin
                    sat_reg <= 1'b1;
                end
                // Carry g and c into the next row.
                if (row_done && !last_reg)
                begin
                    pg_mag_reg <= g_mag_reg;
                    pg_sgn_reg <= g_sgn_reg;
                    pc_mag_reg <= c_mag_reg;
                    pc_sgn_reg <= c_sgn_reg;
                    first_reg  <= 1'b0;
                end
            end

            // Hand over the result and start a fresh vector; otherwise a taken
            // result empties the output register.
            if ((state_reg == S_FINISH) && out_free)
            begin
                res_valid_reg <= 1'b1;
                first_reg     <= 1'b1;
                pg_mag_reg    <= '0;
                pg_sgn_reg    <= 1'b0;
                pc_mag_reg    <= '0;
                pc_sgn_reg    <= 1'b0;
                sum_gg_reg    <= '0;
                sum_ghg_reg   <= '0;
                sat_reg       <= 1'b0;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (row_fire)
        begin
            a_mag_reg <= mag_of(row.sub_diag);
            a_sgn_reg <= row.sub_diag[DATA_WIDTH-1];
            b_mag_reg <= mag_of(row.main_diag);
            b_sgn_reg <= row.main_diag[DATA_WIDTH-1];
            c_mag_reg <= mag_of(row.super_diag);
            c_sgn_reg <= row.super_diag[DATA_WIDTH-1];
            g_mag_reg <= mag_of(row.grad_elem);
            g_sgn_reg <= row.grad_elem[DATA_WIDTH-1];
            last_reg  <= row.last_row;
        end
        if (state_reg == S_CLAMP)
        begin
            if (op_to_t)
            begin
                t_reg     <= prod[ACC_W-1:0];
                t_sgn_reg <= op_sgn;
            end
            else
            begin
                term_reg <= term_next;
            end
        end
        if (state_reg == S_CHECK)
        begin
            err_reg <= tol_fail;
            neg_reg <= sum_ghg_reg[ACC_W-1];
        end
        if ((state_reg == S_FINISH) && out_free)
        begin
            alpha_reg  <= fin_alpha;
            status_reg <= fin_status;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.step_alpha = alpha_reg;
    assign result.status     = status_reg;

`ifndef SYNTH
    // A new result only comes out of the finishing state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result appeared outside the finishing state");

    // A failed tolerance test always reports a zero step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == ST_TOL)) |-> (result.step_alpha == '0))
        else $error("nonzero step reported with tolerance status");

    // While waiting on the divider, it is either running or just finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

    // Handing over a result leaves a cleared vector behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> (first_reg && !sat_reg && (sum_gg_reg == '0)))
        else $error("vector state not cleared after result");
`endif

endmodule

/* verif/tdsl_step_checker.sv */
// Passive scoreboard for the tridiagonal step-length block. It follows every
// accepted transaction on the row, configuration and result channels, keeps
// its own copy of the vector accumulators and the tolerance, and compares each
// result against the oldest predicted step.
module tdsl_step_checker
    import tdsl_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
)
(
    input  logic clk,
    input  logic rst_n,
    tdsl_row_if  row,
    tdsl_cfg_if  cfg,
    tdsl_res_if  result,
    output int   mismatches,
    output int   pending,
    output int   results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDE_W = 2 * ACC_W;

    // Bounds of the signed 64-bit accumulators, seen at double width.
    localparam logic signed [WIDE_W-1:0] WIDE_MAX = $signed({{ACC_W{1'b0}}, SAT_POS});
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = $signed({{ACC_W{1'b1}}, SAT_NEG});

    // Largest quotient magnitudes that fit a Q16.16 result of either sign.
    localparam logic [WIDE_W-1:0] ALPHA_NEG_LIM = 32'h8000_0000;
    localparam logic [WIDE_W-1:0] ALPHA_POS_LIM = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] alpha;
        logic [1:0]         status;
    } step_result_t;

    // Predicted vector state and the tolerance register.
    logic [31:0]              tolerance = 32'd1;
    logic                     row_first = 1'b1;
    logic signed [ACC_W-1:0]  prev_g    = '0;
    logic signed [ACC_W-1:0]  prev_c    = '0;
    logic signed [ACC_W-1:0]  sq_sum    = '0;
    logic signed [ACC_W-1:0]  curv_sum  = '0;
    logic                     vec_sat   = 1'b0;

    step_result_t step_results_q[$];
    step_result_t want;

    // Exact product, clipped to the accumulator range; clipping marks the vector.
    function automatic logic signed [ACC_W-1:0] clip_mul(input logic signed [ACC_W-1:0] x,
                                                         input logic signed [ACC_W-1:0] y);
        logic signed [WIDE_W-1:0] wide;
        wide = x;
        wide = wide * y;
        if (wide > WIDE_MAX)
        begin
            vec_sat = 1'b1;
            return SAT_POS;
        end
        if (wide < WIDE_MIN)
        begin
            vec_sat = 1'b1;
            return SAT_NEG;
        end
        return wide[ACC_W-1:0];
    endfunction

    // Sum clipped to the accumulator range; clipping marks the vector.
    function automatic logic signed [ACC_W-1:0] clip_add(input logic signed [ACC_W-1:0] x,
                                                         input logic signed [ACC_W-1:0] y);
        logic signed [WIDE_W-1:0] wide;
        wide = x;
        wide = wide + y;
        if (wide > WIDE_MAX)
        begin
            vec_sat = 1'b1;
            return SAT_POS;
        end
        if (wide < WIDE_MIN)
        begin
            vec_sat = 1'b1;
            return SAT_NEG;
        end
        return wide[ACC_W-1:0];
    endfunction

    task automatic clear_vector();
        row_first = 1'b1;
        prev_g    = '0;
        prev_c    = '0;
        sq_sum    = '0;
        curv_sum  = '0;
        vec_sat   = 1'b0;
    endtask

    task automatic report_fault(input string msg);
        if (mismatches < 10)
            $display("[%0t] %s", $time, msg);
        mismatches++;
    endtask

    // Folds one Hessian row into g.g and g.Hg; the last row yields the step.
    task automatic fold_row(input logic signed [DATA_WIDTH-1:0] a_in,
                            input logic signed [DATA_WIDTH-1:0] b_in,
                            input logic signed [DATA_WIDTH-1:0] c_in,
                            input logic signed [DATA_WIDTH-1:0] g_in,
                            input logic last);
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-1:0] c;
        logic signed [ACC_W-1:0] g;
        logic signed [ACC_W-1:0] g_pair;
        logic [ACC_W-1:0]        num_mag;
        logic [ACC_W-1:0]        den_mag;
        logic [WIDE_W-1:0]       quot;
        step_result_t            step;

        a = a_in;
        b = b_in;
        c = c_in;
        g = g_in;

        sq_sum   = clip_add(sq_sum, clip_mul(g, g));
        curv_sum = clip_add(curv_sum, clip_mul(clip_mul(b, g), g));

        // Off-diagonal terms need the previous row's gradient and super-diagonal.
        if (!row_first)
        begin
            g_pair   = clip_mul(prev_g, g);
            curv_sum = clip_add(curv_sum, clip_mul(a, g_pair));
            curv_sum = clip_add(curv_sum, clip_mul(prev_c, g_pair));
        end

        if (!last)
        begin
            prev_g    = g;
            prev_c    = c;
            row_first = 1'b0;
            return;
        end

        num_mag = (sq_sum < 0) ? -sq_sum : sq_sum;
        den_mag = (curv_sum < 0) ? -curv_sum : curv_sum;

        if (den_mag == '0 || den_mag < ACC_W'(tolerance))
        begin
            step.alpha  = '0;
            step.status = ST_TOL;
        end
        else
        begin
            step.status = vec_sat ? ST_SAT : ST_OK;
            quot = {{ACC_W{1'b0}}, num_mag} << (FRAC_BITS + 16);
            quot = quot / {{ACC_W{1'b0}}, den_mag};
            if (curv_sum < 0)
            begin
                if (quot > ALPHA_NEG_LIM)
                begin
                    quot        = ALPHA_NEG_LIM;
                    step.status = ST_SAT;
                end
                step.alpha = 32'd0 - quot[31:0];
            end
            else
            begin
                if (quot > ALPHA_POS_LIM)
                begin
                    quot        = ALPHA_POS_LIM;
                    step.status = ST_SAT;
                end
                step.alpha = quot[31:0];
            end
        end

        step_results_q.push_back(step);
        clear_vector();
    endtask

    // Channel monitor: configuration first, then rows, then results.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance = 32'd1;
            clear_vector();
            step_results_q.delete();
            pending         = 0;
            mismatches      = 0;
            results_checked = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                tolerance = cfg.data;

            if (row.valid && row.ready)
                fold_row(row.sub_diag, row.main_diag, row.super_diag, row.grad_elem,
                         row.last_row);

            if (result.valid && result.ready)
            begin
                results_checked++;
                if (step_results_q.size() == 0)
                begin
                    report_fault($sformatf("step result with none pending: alpha %0d status %0d",
                                           result.step_alpha, result.status));
                end
                else
                begin
                    want = step_results_q.pop_front();
                    if (want.alpha !== result.step_alpha || want.status !== result.status)
                        report_fault($sformatf(
                            "step mismatch: alpha exp %0d got %0d, status exp %0d got %0d",
                            want.alpha, result.step_alpha, want.status, result.status));
                end
            end

            pending = step_results_q.size();
        end
    end

endmodule

/* verif/tb_tridiag_exact_step_length.sv */
// Stimulus and verdict for the tridiagonal step-length block. Rows are sent in
// vectors closed by a last row; the checker beside the block predicts and
// compares every step result.
module tb_tridiag_exact_step_length;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WIDTH     = 16;
    localparam int FRAC_BITS      = 8;
    localparam int RAND_PHASES    = 8;
    localparam int ROWS_PER_PHASE = 180;
    // Covers the longest row plus the tolerance check and the divide, rounded up.
    localparam int SETTLE_CYCLES  = 128;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_CHOPPY,
        RX_LAZY
    } rx_pace_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tdsl_row_if #(.DATA_WIDTH(DATA_WIDTH)) row_bus ();
    tdsl_cfg_if                            cfg_bus ();
    tdsl_res_if                            res_bus ();

    int mismatches;
    int pending;
    int results_checked;

    int       rows_sent    = 0;
    int       vectors_sent = 0;
    int       tol_writes   = 0;
    int       burst_left   = 0;
    bit       tx_idle_on   = 1'b0;
    rx_pace_t rx_pace      = RX_STEADY;
    int       rx_wait      = 0;
    int       quiet_cycles = 0;

    tridiag_exact_step_length #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .row   (row_bus),
        .cfg   (cfg_bus),
        .result(res_bus)
    );

    tdsl_step_checker #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) step_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .row            (row_bus),
        .cfg            (cfg_bus),
        .result         (res_bus),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_checked(results_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result receiver: its stall pattern depends on the current pace.
    always @(posedge clk)
    begin
        if (rx_wait != 0)
        begin
            res_bus.ready <= 1'b0;
            rx_wait       <= rx_wait - 1;
        end
        else
        begin
            res_bus.ready <= 1'b1;
            case (rx_pace)
                RX_CHOPPY:
                    if ($urandom_range(0, 3) == 0)
                        rx_wait <= $urandom_range(1, 4);
                RX_LAZY:
                    if ($urandom_range(0, 15) == 0)
                        rx_wait <= $urandom_range(10, 60);
                default:
                    rx_wait <= 0;
            endcase
        end
    end

    // Watchdog: too long without any transaction on any channel ends the run.
    always @(posedge clk)
    begin
        if ((row_bus.valid && row_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Field value: extremes, small magnitudes or full range; tame gives -1, 0 or 1.
    function automatic logic signed [DATA_WIDTH-1:0] pick_field(input bit tame);
        int unsigned roll;
        if (tame)
        begin
            case ($urandom_range(0, 2))
                0:       return -16'sd1;
                1:       return 16'sd0;
                default: return 16'sd1;
            endcase
        end
        roll = $urandom_range(0, 15);
        case (roll)
            0:             return 16'sh8000;
            1:             return 16'sh7FFF;
            2:             return 16'sd0;
            3:             return -16'sd1;
            4, 5, 6, 7:    return 16'(int'($urandom_range(0, 600)) - 300);
            default:       return 16'($urandom);
        endcase
    endfunction

    // One row transaction; starts and ends on a rising edge.
    task automatic put_row(input logic signed [DATA_WIDTH-1:0] a,
                           input logic signed [DATA_WIDTH-1:0] b,
                           input logic signed [DATA_WIDTH-1:0] c,
                           input logic signed [DATA_WIDTH-1:0] g,
                           input logic last);
        int   gap;
        logic took;
        if (tx_idle_on && burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 40);
            row_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        row_bus.valid      <= 1'b1;
        row_bus.sub_diag   <= a;
        row_bus.main_diag  <= b;
        row_bus.super_diag <= c;
        row_bus.grad_elem  <= g;
        row_bus.last_row   <= last;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = row_bus.ready;
            @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        rows_sent++;
        if (last)
            vectors_sent++;
    endtask

    task automatic send_vector(input int len, input bit tame);
        for (int i = 0; i < len; i++)
            put_row(pick_field(tame), pick_field(tame), pick_field(tame), pick_field(1'b0),
                    i == len - 1);
    endtask

    // Writes the tolerance register; only called while the block is idle.
    task automatic set_tolerance(input logic [31:0] value);
        logic took;
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = cfg_bus.ready;
            @(posedge clk);
        end
        cfg_bus.valid <= 1'b0;
        tol_writes++;
    endtask

    // Waits until every predicted step has arrived and the sequencer is done.
    task automatic drain_results();
        row_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int          len;
        int          phase_rows;
        int unsigned roll;
        logic [31:0] tol;

        row_bus.valid      <= 1'b0;
        row_bus.sub_diag   <= '0;
        row_bus.main_diag  <= '0;
        row_bus.super_diag <= '0;
        row_bus.grad_elem  <= '0;
        row_bus.last_row   <= 1'b0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.data       <= '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed vectors under the reset tolerance of one.
        // Single rows at the extremes; the ignored neighbor fields are extreme too.
        put_row(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
        put_row(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1);
        // Zero gradient: zero denominator.
        put_row(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
        // Tiny positive and negative denominators: the step saturates.
        put_row(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh7FFF, 1'b0);
        put_row(16'sh0000, 16'sh0001, 16'sh8000, 16'sh0001, 1'b1);
        put_row(16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 1'b0);
        put_row(16'sh0000, 16'shFFFF, 16'sh7FFF, 16'sh0001, 1'b1);
        // All fields at alternating extremes over three rows.
        put_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        put_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
        put_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
        // Only the off-diagonal terms contribute: the step is exactly one.
        put_row(16'sh0000, 16'sh0000, 16'sh0100, 16'sh0100, 1'b0);
        put_row(16'sh0100, 16'sh0000, 16'sh0000, 16'sh0100, 1'b1);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain_results();
            case (p)
                0:               tol = 32'd0;
                1:               tol = 32'hFFFF_FFFF;
                2:               tol = 32'h0100_0000;
                RAND_PHASES - 1: tol = 32'd1;
                default:         tol = ($urandom_range(0, 1) != 0) ? $urandom
                                                                    : $urandom_range(0, 1 << 20);
            endcase
            set_tolerance(tol);
            tx_idle_on = (p % 3 != 0);
            rx_pace    = rx_pace_t'((p / 3) % 3);

            // Directed vectors for the special tolerance settings.
            case (p)
                0:
                begin
                    // Zero tolerance still rejects an exactly zero denominator.
                    put_row(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
                    put_row(16'sh0001, 16'sh0000, 16'sh0001, 16'sh7FFF, 1'b1);
                    put_row(16'sh0000, 16'sh0001, 16'sh0000, 16'sh0001, 1'b1);
                end
                1:
                begin
                    // Largest tolerance: small denominators fail, the largest passes.
                    put_row(16'sh0000, 16'sh0100, 16'sh0000, 16'sh0100, 1'b1);
                    put_row(16'sh0000, 16'sh7FFF, 16'sh0000, 16'sh7FFF, 1'b1);
                end
                2:
                begin
                    // Denominator equal to the tolerance passes; just below fails.
                    put_row(16'sh0000, 16'sh0100, 16'sh0000, 16'sh0100, 1'b1);
                    put_row(16'sh0000, 16'sh0100, 16'sh0000, 16'sh00FF, 1'b1);
                end
                default:
                    phase_rows = 0;
            endcase

            // Random vectors: mostly short, a few long, some near singular.
            phase_rows = 0;
            while (phase_rows < ROWS_PER_PHASE)
            begin
                roll = $urandom_range(0, 15);
                if (roll < 4)
                    len = 1;
                else if (roll == 15)
                    len = $urandom_range(10, 40);
                else
                    len = $urandom_range(2, 6);
                send_vector(len, $urandom_range(0, 7) == 0);
                phase_rows += len;
            end
        end

        drain_results();
        $display("Covered %0d rows in %0d vectors across %0d tolerance writes", rows_sent,
                 vectors_sent, tol_writes);
        $display("Compared %0d step results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
